FILE: src/ncwh_pkg.sv
// shared constants, codes and types for the nearest-centroid word histogram
`timescale 1ns / 1ps

package ncwh_pkg;

  localparam int DEF_MAX_WORDS  = 64;
  localparam int DEF_DIMS       = 128;
  localparam int DEF_COUNT_BITS = 16;

  localparam int OP_W        = 2;
  localparam int WIDX_W      = 6;
  localparam int DIDX_W      = 7;
  localparam int ELEM_W      = 16;
  localparam int FEAT_W      = 8;
  localparam int WORD_W      = 6;
  localparam int HIT_W       = 16;
  localparam int TOTAL_W     = 22;
  localparam int FREQ_W      = 16;
  localparam int NUM_WORDS_W = 7;
  localparam int SQ_W        = 32;
  localparam int DIV_CNT_W   = 4;

  localparam logic [NUM_WORDS_W-1:0] NUM_WORDS_RST = 7'd50;
  localparam logic [FREQ_W-1:0]      FREQ_MAX      = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_CB_WRITE  = 2'd0,
    OP_FEATURE   = 2'd1,
    OP_END_IMAGE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_RUN,
    SR_DRAIN,
    SR_FIN
  } srch_state_t;

  typedef enum logic [2:0] {
    H_IDLE,
    H_INC,
    H_SUM,
    H_LOAD,
    H_DIV,
    H_OUT
  } hist_state_t;

  typedef struct packed {
    logic cb_we;
    logic fb_we;
    logic start;
  } srch_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } srch_stat_t;

  typedef struct packed {
    logic inc;
    logic report;
  } hist_ctl_t;

endpackage

FILE: src/ncwh_if.sv
// valid/ready channel interfaces for input words and histogram results
`timescale 1ns / 1ps

interface ncwh_in_if import ncwh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [WIDX_W-1:0] word_index;
  logic [DIDX_W-1:0] dim_index;
  logic [ELEM_W-1:0] elem_value;

  modport source (output valid, op, word_index, dim_index, elem_value, input ready);
  modport sink   (input valid, op, word_index, dim_index, elem_value, output ready);
endinterface

interface ncwh_out_if import ncwh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  word;
  logic [HIT_W-1:0]   hit_count;
  logic [TOTAL_W-1:0] total_count;
  logic [FREQ_W-1:0]  frequency;
  logic               last_bin;

  modport source (output valid, word, hit_count, total_count, frequency, last_bin,
                  input ready);
  modport sink   (input valid, word, hit_count, total_count, frequency, last_bin,
                  output ready);
endinterface

FILE: src/ncwh_search.sv
// codebook and feature memories with streaming squared-distance search
`timescale 1ns / 1ps

module ncwh_search import ncwh_pkg::*; #(
  parameter int MAX_WORDS = DEF_MAX_WORDS,
  parameter int DIMS      = DEF_DIMS,
  localparam int WA_W     = $clog2(MAX_WORDS),
  localparam int DA_W     = (DIMS > 1) ? $clog2(DIMS) : 1,
  localparam int CB_AW    = $clog2(MAX_WORDS * DIMS),
  localparam int NW_W     = $clog2(MAX_WORDS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  srch_ctl_t         ctl,
  input  logic [CB_AW-1:0]  cb_waddr,
  input  logic [ELEM_W-1:0] cb_wdata,
  input  logic [DA_W-1:0]   fb_waddr,
  input  logic [FEAT_W-1:0] fb_wdata,
  input  logic [NW_W-1:0]   n_words,
  output srch_stat_t        stat,
  output logic [WA_W-1:0]   best_word
);

  localparam int DIST_W = SQ_W + $clog2(DIMS);

  srch_state_t state_r, state_nxt;

  logic [ELEM_W-1:0] cb_mem [MAX_WORDS*DIMS];
  logic [FEAT_W-1:0] fb_mem [DIMS];

  logic [DA_W-1:0]   d_cnt_r;
  logic [WA_W-1:0]   w_cnt_r;
  logic [CB_AW-1:0]  cb_addr_r;

  logic              issue, last_d, last_w, final_elem;

  logic [ELEM_W-1:0] cb_q_r;
  logic [FEAT_W-1:0] fb_q_r;
  logic              s1_vld_r, s1_last_r, s1_fin_r;
  logic [WA_W-1:0]   s1_word_r;

  logic [ELEM_W-1:0] ad_r;
  logic              s2_vld_r, s2_last_r, s2_fin_r;
  logic [WA_W-1:0]   s2_word_r;

  logic [SQ_W-1:0]   sq_r;
  logic              s3_vld_r, s3_last_r, s3_fin_r;
  logic [WA_W-1:0]   s3_word_r;

  logic [DIST_W-1:0] acc_r, best_r, acc_sum;
  logic [WA_W-1:0]   best_idx_r;
  logic [ELEM_W-1:0] f_scaled;

  assign issue      = (state_r == SR_RUN);
  assign last_d     = (d_cnt_r == DA_W'(DIMS - 1));
  assign last_w     = ((NW_W'(w_cnt_r) + NW_W'(1)) == n_words);
  assign final_elem = issue && last_d && last_w;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SR_IDLE:  if (ctl.start) state_nxt = SR_RUN;
      SR_RUN:   if (final_elem) state_nxt = SR_DRAIN;
      SR_DRAIN: if (s3_vld_r && s3_fin_r) state_nxt = SR_FIN;
      SR_FIN:   state_nxt = SR_IDLE;
      default:  state_nxt = SR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    stat.busy = (state_r != SR_IDLE);
    stat.done = (state_r == SR_FIN);
  end

  assign best_word = best_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // element address counters
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      d_cnt_r   <= '0;
      w_cnt_r   <= '0;
      cb_addr_r <= '0;
    end else if (issue) begin
      cb_addr_r <= cb_addr_r + CB_AW'(1);
      if (last_d) begin
        d_cnt_r <= '0;
        w_cnt_r <= w_cnt_r + WA_W'(1);
      end else begin
        d_cnt_r <= d_cnt_r + DA_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cb_we) begin
      cb_mem[cb_waddr] <= cb_wdata;
    end
    cb_q_r <= cb_mem[cb_addr_r];
  end

  always_ff @(posedge clk) begin
    if (ctl.fb_we) begin
      fb_mem[fb_waddr] <= fb_wdata;
    end
    fb_q_r <= fb_mem[d_cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  assign f_scaled = {fb_q_r, 8'h00};

  // absolute difference, then square
  always_ff @(posedge clk) begin
    s1_last_r <= last_d;
    s1_fin_r  <= final_elem;
    s1_word_r <= w_cnt_r;

    ad_r      <= (f_scaled >= cb_q_r) ? (f_scaled - cb_q_r) : (cb_q_r - f_scaled);
    s2_last_r <= s1_last_r;
    s2_fin_r  <= s1_fin_r;
    s2_word_r <= s1_word_r;

    sq_r      <= SQ_W'(ad_r * ad_r);
    s3_last_r <= s2_last_r;
    s3_fin_r  <= s2_fin_r;
    s3_word_r <= s2_word_r;
  end

  assign acc_sum = acc_r + DIST_W'(sq_r);

  // accumulate and keep the running minimum
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r <= '0;
    end else if (s3_vld_r) begin
      if (s3_last_r) begin
        acc_r <= '0;
        if ((s3_word_r == '0) || (acc_sum < best_r)) begin
          best_r     <= acc_sum;
          best_idx_r <= s3_word_r;
        end
      end else begin
        acc_r <= acc_sum;
      end
    end
  end

endmodule

FILE: src/ncwh_hist.sv
// histogram memory with saturating update, totals and serial frequency divide
`timescale 1ns / 1ps

module ncwh_hist import ncwh_pkg::*; #(
  parameter int MAX_WORDS  = DEF_MAX_WORDS,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  localparam int WA_W      = $clog2(MAX_WORDS),
  localparam int NW_W      = $clog2(MAX_WORDS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  hist_ctl_t       ctl,
  input  logic [WA_W-1:0] inc_word,
  input  logic [NW_W-1:0] n_words,
  output logic            busy,
  ncwh_out_if.source      out_ch
);

  localparam int TOT_W      = COUNT_BITS + WA_W;
  localparam int CNT_EXT_W  = (COUNT_BITS > HIT_W) ? COUNT_BITS : HIT_W;
  localparam int TOT_EXT_W  = (TOT_W > TOTAL_W) ? TOT_W : TOTAL_W;
  localparam int WORD_EXT_W = (WA_W > WORD_W) ? WA_W : WORD_W;

  hist_state_t state_r, state_nxt;

  logic [COUNT_BITS-1:0] hist_mem [MAX_WORDS];
  logic                  hv_r [MAX_WORDS];

  logic [WA_W-1:0]       rd_addr;
  logic [COUNT_BITS-1:0] rd_q_r;
  logic                  rv_q_r;
  logic [COUNT_BITS-1:0] cur_cnt;

  logic [NW_W-1:0]       ptr_r;
  logic [WA_W-1:0]       widx_r;
  logic [TOT_W-1:0]      total_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [TOT_W-1:0]      rem_r;
  logic [FREQ_W-1:0]     q_r;
  logic [DIV_CNT_W-1:0]  bit_r;

  logic                  sum_done, last_word, out_take, quick;
  logic [TOT_W:0]        rem2;
  logic [CNT_EXT_W-1:0]  cnt_ext;
  logic [TOT_EXT_W-1:0]  tot_ext;
  logic [WORD_EXT_W-1:0] word_ext;

  assign cur_cnt   = rv_q_r ? rd_q_r : '0;
  assign sum_done  = (ptr_r == n_words);
  assign last_word = ((ptr_r + NW_W'(1)) == n_words);
  assign out_take  = (state_r == H_OUT) && out_ch.ready;
  assign quick     = (total_r == '0) || (TOT_W'(cur_cnt) == total_r);
  assign rem2      = {rem_r, 1'b0};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      H_IDLE: begin
        if (ctl.report) begin
          state_nxt = H_SUM;
        end else if (ctl.inc) begin
          state_nxt = H_INC;
        end
      end
      H_INC:  state_nxt = H_IDLE;
      H_SUM:  if (sum_done) state_nxt = H_LOAD;
      H_LOAD: state_nxt = quick ? H_OUT : H_DIV;
      H_DIV:  if (bit_r == DIV_CNT_W'(FREQ_W - 1)) state_nxt = H_OUT;
      H_OUT: begin
        if (out_ch.ready) begin
          state_nxt = last_word ? H_IDLE : H_LOAD;
        end
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy         = (state_r != H_IDLE);
    out_ch.valid = (state_r == H_OUT);
    case (state_r)
      H_IDLE:  rd_addr = ctl.report ? '0 : inc_word;
      H_SUM:   rd_addr = sum_done ? '0 : ptr_r[WA_W-1:0];
      H_OUT:   rd_addr = WA_W'(ptr_r + NW_W'(1));
      default: rd_addr = ptr_r[WA_W-1:0];
    endcase
  end

  assign cnt_ext  = CNT_EXT_W'(cnt_r);
  assign tot_ext  = TOT_EXT_W'(total_r);
  assign word_ext = WORD_EXT_W'(ptr_r);

  assign out_ch.word        = word_ext[WORD_W-1:0];
  assign out_ch.hit_count   = cnt_ext[HIT_W-1:0];
  assign out_ch.total_count = tot_ext[TOTAL_W-1:0];
  assign out_ch.frequency   = q_r;
  assign out_ch.last_bin    = last_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == H_INC) && (cur_cnt != '1)) begin
      hist_mem[widx_r] <= cur_cnt + COUNT_BITS'(1);
    end else if (state_r == H_INC) begin
      hist_mem[widx_r] <= cur_cnt;
    end
    rd_q_r <= hist_mem[rd_addr];
    rv_q_r <= hv_r[rd_addr];
  end

  // bin valid bits, cleared at once after the last word goes out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_WORDS; i++) hv_r[i] <= 1'b0;
    end else if (out_take && last_word) begin
      for (int i = 0; i < MAX_WORDS; i++) hv_r[i] <= 1'b0;
    end else if (state_r == H_INC) begin
      hv_r[widx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      H_IDLE: begin
        widx_r <= inc_word;
        if (ctl.report) begin
          ptr_r   <= NW_W'(1);
          total_r <= '0;
        end
      end
      H_SUM: begin
        total_r <= total_r + TOT_W'(cur_cnt);
        ptr_r   <= sum_done ? '0 : (ptr_r + NW_W'(1));
      end
      H_LOAD: begin
        cnt_r <= cur_cnt;
        rem_r <= TOT_W'(cur_cnt);
        bit_r <= '0;
        q_r   <= (total_r == '0) ? '0 : (quick ? FREQ_MAX : '0);
      end
      H_DIV: begin
        bit_r <= bit_r + DIV_CNT_W'(1);
        if (rem2 >= {1'b0, total_r}) begin
          rem_r <= TOT_W'(rem2 - {1'b0, total_r});
          q_r   <= {q_r[FREQ_W-2:0], 1'b1};
        end else begin
          rem_r <= rem2[TOT_W-1:0];
          q_r   <= {q_r[FREQ_W-2:0], 1'b0};
        end
      end
      H_OUT: begin
        if (out_ch.ready && !last_word) begin
          ptr_r <= ptr_r + NW_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/nearest_centroid_word_histogram_top.sv
// top level of the nearest-centroid word histogram quantiser
`timescale 1ns / 1ps

// Codebook and feature words are taken one per cycle while the search and histogram are idle.
// The word carrying the last descriptor dimension starts a search that streams the codebook
// through its single read port, one element per cycle, then a histogram update; during both
// no word is accepted. An end-of-image word reads every bin once to form the total, then for
// each bin runs a bit-serial frequency divide (skipped when the total is zero or the bin holds
// it all) before its result is offered; the next bin starts once that result is taken, and the
// histogram is empty again after the last one. Nothing is cleared by a pass after reset:
// codebook and feature entries must be written before they are used.

module nearest_centroid_word_histogram_top import ncwh_pkg::*; #(
  parameter int MAX_WORDS  = DEF_MAX_WORDS,
  parameter int DIMS       = DEF_DIMS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  ncwh_in_if.sink                in_ch,
  ncwh_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  logic [NUM_WORDS_W-1:0] cfg_wdata
);

  localparam int WA_W  = $clog2(MAX_WORDS);
  localparam int DA_W  = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int CB_AW = $clog2(MAX_WORDS * DIMS);
  localparam int NW_W  = $clog2(MAX_WORDS + 1);

  logic [NUM_WORDS_W-1:0] num_words_r;
  logic [NW_W-1:0]        n_words;
  logic                   accept, widx_ok, didx_ok, didx_last;
  logic [31:0]            widx_ext, didx_ext, cb_lin;
  srch_ctl_t              srch_ctl;
  srch_stat_t             srch_stat;
  hist_ctl_t              hist_ctl;
  logic [WA_W-1:0]        best_word;
  logic                   hist_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_words_r <= NUM_WORDS_RST;
    end else if (cfg_we) begin
      num_words_r <= cfg_wdata;
    end
  end

  // words in use, forced into 1..MAX_WORDS
  always_comb begin
    if (num_words_r == '0) begin
      n_words = NW_W'(1);
    end else if (32'(num_words_r) > 32'(MAX_WORDS)) begin
      n_words = NW_W'(MAX_WORDS);
    end else begin
      n_words = NW_W'(num_words_r);
    end
  end

  assign in_ch.ready = !srch_stat.busy && !hist_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  assign widx_ext  = 32'(in_ch.word_index);
  assign didx_ext  = 32'(in_ch.dim_index);
  assign widx_ok   = (widx_ext < 32'(MAX_WORDS));
  assign didx_ok   = (didx_ext < 32'(DIMS));
  assign didx_last = (didx_ext == 32'(DIMS - 1));
  assign cb_lin    = widx_ext * 32'(DIMS) + didx_ext;

  always_comb begin
    srch_ctl = '0;
    hist_ctl = '0;
    case (op_t'(in_ch.op))
      OP_CB_WRITE: begin
        srch_ctl.cb_we = accept && widx_ok && didx_ok;
      end
      OP_FEATURE: begin
        srch_ctl.fb_we = accept && didx_ok;
        srch_ctl.start = accept && didx_last;
      end
      OP_END_IMAGE: begin
        hist_ctl.report = accept;
      end
      default: begin
      end
    endcase
    hist_ctl.inc = srch_stat.done;
  end

  ncwh_search #(
    .MAX_WORDS (MAX_WORDS),
    .DIMS      (DIMS)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (srch_ctl),
    .cb_waddr  (cb_lin[CB_AW-1:0]),
    .cb_wdata  (in_ch.elem_value),
    .fb_waddr  (didx_ext[DA_W-1:0]),
    .fb_wdata  (in_ch.elem_value[FEAT_W-1:0]),
    .n_words   (n_words),
    .stat      (srch_stat),
    .best_word (best_word)
  );

  ncwh_hist #(
    .MAX_WORDS  (MAX_WORDS),
    .COUNT_BITS (COUNT_BITS)
  ) u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hist_ctl),
    .inc_word (best_word),
    .n_words  (n_words),
    .busy     (hist_busy),
    .out_ch   (out_ch)
  );

endmodule
